/* rtl/core/ffa_pkg.sv */
// ----------------------------------------------------------------------------
// ffa_pkg
// shared types, constants and helpers of the field force acceleration block
// ----------------------------------------------------------------------------
`default_nettype none

package ffa_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DIV_STEPS     = 31;

  localparam logic [1:0] KIND_GRAVITY  = 2'd0;
  localparam logic [1:0] KIND_ELECTRIC = 2'd1;
  localparam logic [1:0] KIND_MAGNETIC = 2'd2;

  localparam logic [2:0] REG_KIND  = 3'd0;
  localparam logic [2:0] REG_MAG   = 3'd1;
  localparam logic [2:0] REG_DIR_X = 3'd2;
  localparam logic [2:0] REG_DIR_Y = 3'd3;
  localparam logic [2:0] REG_DIR_Z = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_STATIC    = 2'd1;
  localparam logic [1:0] ST_BAD_MASS  = 2'd2;
  localparam logic [1:0] ST_NO_CHARGE = 2'd3;

  typedef struct packed {
    logic               is_fixed;
    logic signed [31:0] body_mass;
    logic signed [31:0] body_charge;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] acc_in_x;
    logic signed [31:0] acc_in_y;
    logic signed [31:0] acc_in_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] acc_out_x;
    logic signed [31:0] acc_out_y;
    logic signed [31:0] acc_out_z;
    logic [1:0]         status;
  } out_t;

  typedef struct packed {
    logic signed [31:0] magnitude;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic [1:0]         kind;
  } field_t;

  // item state carried alongside the divider
  typedef struct packed {
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
    logic signed [31:0] acc_z;
    logic signed [31:0] d_x;
    logic signed [31:0] d_y;
    logic signed [31:0] d_z;
    logic [1:0]         status;
    logic               apply;
    logic               grav;
    logic               neg;
    logic               ovf;
  } mid_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sh0000_0000_7fff_ffff) begin
      r = 32'sh7fff_ffff;
    end else if (x < -64'sh0000_0000_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/ffa_front.sv */
// ----------------------------------------------------------------------------
// ffa_front
// input register, status checks, charge product, cross product (field direction for electric) and divider operands
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_front #(
  parameter int FRAC_BITS = ffa_pkg::FRAC_BITS_DEF
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  input  ffa_pkg::in_t        in_item,
  input  ffa_pkg::field_t     field,
  output logic                valid,
  output ffa_pkg::mid_t       mid,
  output logic [31:0]         rem,
  output logic [30:0]         low,
  output logic [31:0]         mass
);

  // stage a
  logic         va;
  ffa_pkg::in_t ia;

  // stage b
  logic               vb;
  ffa_pkg::in_t       ib;
  logic [1:0]         status_b;
  logic               apply_b;
  logic               grav_b;
  logic               elec_b;
  logic signed [63:0] p_yz, p_zy, p_zx, p_xz, p_xy, p_yx, num_b;

  logic [1:0]  status_a;
  logic        mag_kind_a;
  logic [63:0] num_abs;
  logic        neg_c;
  logic        ovf_c;

  always_comb begin
    mag_kind_a = (field.kind == ffa_pkg::KIND_ELECTRIC) ||
                 (field.kind == ffa_pkg::KIND_MAGNETIC);
    if (ia.is_fixed) begin
      status_a = ffa_pkg::ST_STATIC;
    end else if (mag_kind_a && (ia.body_mass <= 32'sd0)) begin
      status_a = ffa_pkg::ST_BAD_MASS;
    end else if ((field.kind == ffa_pkg::KIND_MAGNETIC) && (ia.body_charge == 32'sd0)) begin
      status_a = ffa_pkg::ST_NO_CHARGE;
    end else begin
      status_a = ffa_pkg::ST_OK;
    end
  end

  always_comb begin
    neg_c   = num_b[63];
    num_abs = neg_c ? (64'd0 - 64'(num_b)) : 64'(num_b);
    ovf_c   = {1'b0, num_abs[63:31]} >= {3'b000, ib.body_mass[30:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va    <= 1'b0;
      vb    <= 1'b0;
      valid <= 1'b0;
    end else begin
      va    <= in_valid;
      vb    <= va;
      valid <= vb;
    end
    ia       <= in_item;
    ib       <= ia;
    status_b <= status_a;
    apply_b  <= (status_a == ffa_pkg::ST_OK) &&
                ((field.kind == ffa_pkg::KIND_GRAVITY) || mag_kind_a);
    grav_b   <= field.kind == ffa_pkg::KIND_GRAVITY;
    elec_b   <= field.kind == ffa_pkg::KIND_ELECTRIC;
    p_yz     <= ia.vel_y * field.dir_z;
    p_zy     <= ia.vel_z * field.dir_y;
    p_zx     <= ia.vel_z * field.dir_x;
    p_xz     <= ia.vel_x * field.dir_z;
    p_xy     <= ia.vel_x * field.dir_y;
    p_yx     <= ia.vel_y * field.dir_x;
    num_b    <= ia.body_charge * field.magnitude;

    mid.acc_x  <= ib.acc_in_x;
    mid.acc_y  <= ib.acc_in_y;
    mid.acc_z  <= ib.acc_in_z;
    mid.d_x    <= elec_b ? field.dir_x : ffa_pkg::sat32((p_yz >>> FRAC_BITS) - (p_zy >>> FRAC_BITS));
    mid.d_y    <= elec_b ? field.dir_y : ffa_pkg::sat32((p_zx >>> FRAC_BITS) - (p_xz >>> FRAC_BITS));
    mid.d_z    <= elec_b ? field.dir_z : ffa_pkg::sat32((p_xy >>> FRAC_BITS) - (p_yx >>> FRAC_BITS));
    mid.status <= status_b;
    mid.apply  <= apply_b;
    mid.grav   <= grav_b;
    mid.neg    <= neg_c;
    mid.ovf    <= ovf_c;
    rem        <= ovf_c ? 32'd0 : num_abs[62:31];
    low        <= num_abs[30:0];
    mass       <= ib.body_mass;
  end

endmodule

`default_nettype wire

/* rtl/core/ffa_div.sv */
// ----------------------------------------------------------------------------
// ffa_div
// restoring divider, one quotient bit per pipeline stage
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_div (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  input  ffa_pkg::mid_t       in_mid,
  input  wire [31:0]          in_rem,
  input  wire [30:0]          in_low,
  input  wire [31:0]          in_mass,
  output logic                valid,
  output ffa_pkg::mid_t       mid,
  output logic [30:0]         quot
);

  localparam int N = ffa_pkg::DIV_STEPS;

  // stage registers
  logic          v_s    [0:N-1];
  ffa_pkg::mid_t mid_s  [0:N-1];
  logic [31:0]   rem_s  [0:N-1];
  logic [30:0]   low_s  [0:N-1];
  logic [30:0]   q_s    [0:N-1];
  logic [31:0]   mass_s [0:N-1];

  // stage inputs
  logic          v_c    [0:N-1];
  ffa_pkg::mid_t mid_c  [0:N-1];
  logic [31:0]   rem_c  [0:N-1];
  logic [30:0]   low_c  [0:N-1];
  logic [30:0]   q_c    [0:N-1];
  logic [31:0]   mass_c [0:N-1];
  logic [31:0]   sh_c   [0:N-1];
  logic          ge_c   [0:N-1];

  always_comb begin
    v_c[0]    = in_valid;
    mid_c[0]  = in_mid;
    rem_c[0]  = in_rem;
    low_c[0]  = in_low;
    q_c[0]    = '0;
    mass_c[0] = in_mass;
    for (int k = 1; k < N; k++) begin
      v_c[k]    = v_s[k-1];
      mid_c[k]  = mid_s[k-1];
      rem_c[k]  = rem_s[k-1];
      low_c[k]  = low_s[k-1];
      q_c[k]    = q_s[k-1];
      mass_c[k] = mass_s[k-1];
    end
    for (int k = 0; k < N; k++) begin
      sh_c[k] = {rem_c[k][30:0], low_c[k][30]};
      ge_c[k] = sh_c[k] >= mass_c[k];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < N; k++) begin
      if (rst) begin
        v_s[k] <= 1'b0;
      end else begin
        v_s[k] <= v_c[k];
      end
      mid_s[k]  <= mid_c[k];
      rem_s[k]  <= ge_c[k] ? (sh_c[k] - mass_c[k]) : sh_c[k];
      low_s[k]  <= {low_c[k][29:0], 1'b0};
      q_s[k]    <= {q_c[k][29:0], ge_c[k]};
      mass_s[k] <= mass_c[k];
    end
  end

  assign valid = v_s[N-1];
  assign mid   = mid_s[N-1];
  assign quot  = q_s[N-1];

endmodule

`default_nettype wire

/* rtl/core/ffa_back.sv */
// ----------------------------------------------------------------------------
// ffa_back
// factor saturation, field term products and saturating accumulate
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_back #(
  parameter int FRAC_BITS = ffa_pkg::FRAC_BITS_DEF
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  input  ffa_pkg::mid_t       in_mid,
  input  wire [30:0]          quot,
  input  ffa_pkg::field_t     field,
  output logic                done,
  output ffa_pkg::out_t       result
);

  logic signed [31:0] f;
  logic signed [31:0] a;
  logic signed [31:0] bx, by, bz;

  logic               vp;
  ffa_pkg::mid_t      mp;
  logic signed [63:0] px, py, pz;

  always_comb begin
    if (in_mid.ovf) begin
      f = in_mid.neg ? -32'sh8000_0000 : 32'sh7fff_ffff;
    end else if (in_mid.neg) begin
      f = 32'sd0 - $signed({1'b0, quot});
    end else begin
      f = $signed({1'b0, quot});
    end
    a  = in_mid.grav ? field.magnitude : f;
    bx = in_mid.grav ? field.dir_x : in_mid.d_x;
    by = in_mid.grav ? field.dir_y : in_mid.d_y;
    bz = in_mid.grav ? field.dir_z : in_mid.d_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vp   <= 1'b0;
      done <= 1'b0;
    end else begin
      vp   <= in_valid;
      done <= vp;
    end
    mp <= in_mid;
    px <= a * bx;
    py <= a * by;
    pz <= a * bz;
    result.acc_out_x <= ffa_pkg::sat32(64'(mp.acc_x) + (mp.apply ? (px >>> FRAC_BITS) : 64'sd0));
    result.acc_out_y <= ffa_pkg::sat32(64'(mp.acc_y) + (mp.apply ? (py >>> FRAC_BITS) : 64'sd0));
    result.acc_out_z <= ffa_pkg::sat32(64'(mp.acc_z) + (mp.apply ? (pz >>> FRAC_BITS) : 64'sd0));
    result.status    <= mp.status;
  end

endmodule

`default_nettype wire

/* rtl/core/field_force_acceleration.sv */
// ----------------------------------------------------------------------------
// field_force_acceleration
// adds the acceleration of one configured field to a stream of particles
// ----------------------------------------------------------------------------
// A new particle is taken on every cycle that start is high; busy stays low.
// Each transaction yields one result, shown for one cycle with done high,
// after it passes the front registers, the pipelined divider (one quotient
// bit per stage) and the back registers. The receiver cannot stall,
// so results must be taken when done is high. Field registers are written
// through cfg_we / cfg_index / cfg_data and may change only while no
// transaction is in flight.
`default_nettype none

module field_force_acceleration #(
  parameter int FRAC_BITS = ffa_pkg::FRAC_BITS_DEF
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  output logic                busy,
  input  ffa_pkg::in_t        item,
  output logic                done,
  output ffa_pkg::out_t       result,
  input  wire                 cfg_we,
  input  wire [2:0]           cfg_index,
  input  wire [31:0]          cfg_data
);

  ffa_pkg::field_t field;

  logic          f_valid;
  ffa_pkg::mid_t f_mid;
  logic [31:0]   f_rem;
  logic [30:0]   f_low;
  logic [31:0]   f_mass;

  logic          d_valid;
  ffa_pkg::mid_t d_mid;
  logic [30:0]   d_quot;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      field <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ffa_pkg::REG_KIND:  field.kind      <= cfg_data[1:0];
        ffa_pkg::REG_MAG:   field.magnitude <= cfg_data;
        ffa_pkg::REG_DIR_X: field.dir_x     <= cfg_data;
        ffa_pkg::REG_DIR_Y: field.dir_y     <= cfg_data;
        ffa_pkg::REG_DIR_Z: field.dir_z     <= cfg_data;
        default: ;
      endcase
    end
  end

  ffa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start && !busy),
    .in_item  (item),
    .field    (field),
    .valid    (f_valid),
    .mid      (f_mid),
    .rem      (f_rem),
    .low      (f_low),
    .mass     (f_mass)
  );

  ffa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (f_valid),
    .in_mid   (f_mid),
    .in_rem   (f_rem),
    .in_low   (f_low),
    .in_mass  (f_mass),
    .valid    (d_valid),
    .mid      (d_mid),
    .quot     (d_quot)
  );

  ffa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (d_valid),
    .in_mid   (d_mid),
    .quot     (d_quot),
    .field    (field),
    .done     (done),
    .result   (result)
  );

endmodule

`default_nettype wire
